/* rtl/sfxa_pkg.sv */
// ----------------------------------------------------------------------------
// sfxa_pkg
// Shared types and constants for the signed fixed-point to decimal text core.
// ----------------------------------------------------------------------------
package sfxa_pkg;

  // field widths
  localparam int NUM_W    = 32;
  localparam int PLACES_W = 4;
  localparam int CAP_W    = 8;
  localparam int CHAR_W   = 7;

  // digit store
  localparam int NUM_DIGITS  = 10;
  localparam int DIGIT_IDX_W = 4;
  localparam int DIGIT_W     = 4;

  localparam logic [PLACES_W-1:0] MAX_PLACES = 4'd9;

  // ascii codes
  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] ASCII_POINT = 7'h2E;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] ASCII_NONE  = 7'h00;

  // reciprocal of ten: q = (x * RECIP_TEN) >> RECIP_SHIFT, exact for 32-bit x
  localparam logic [NUM_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int               RECIP_SHIFT = 35;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_CHECK,
    S_SIGN,
    S_DIGIT,
    S_POINT,
    S_FAIL
  } state_t;

  typedef enum logic [1:0] {
    CHAR_FAIL,
    CHAR_SIGN,
    CHAR_DIGIT,
    CHAR_POINT
  } char_sel_t;

  typedef struct packed {
    logic      load;
    logic      div_step;
    logic      load_k;
    logic      digit_dec;
    char_sel_t sel;
  } cmd_t;

  typedef struct packed {
    logic fits;
    logic neg;
    logic div_done;
    logic k_zero;
    logic k_at_point;
  } status_t;

endpackage

/* rtl/sfxa_in_if.sv */
// ----------------------------------------------------------------------------
// sfxa_in_if
// Input channel: value, decimal places and buffer capacity with valid/ready.
// ----------------------------------------------------------------------------
interface sfxa_in_if import sfxa_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [NUM_W-1:0]    number;
  logic        [PLACES_W-1:0] decimal_places;
  logic        [CAP_W-1:0]    capacity;

  modport source (output valid, number, decimal_places, capacity, input ready);
  modport sink   (input valid, number, decimal_places, capacity, output ready);
endinterface

/* rtl/sfxa_out_if.sv */
// ----------------------------------------------------------------------------
// sfxa_out_if
// Output channel: one text character per word with valid/ready.
// ----------------------------------------------------------------------------
interface sfxa_out_if import sfxa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              fits;
  logic              last;

  modport source (output valid, char_code, fits, last, input ready);
  modport sink   (input valid, char_code, fits, last, output ready);
endinterface

/* rtl/sfxa_datapath.sv */
// ----------------------------------------------------------------------------
// sfxa_datapath
// Magnitude register, divide-by-ten step, digit store, length check and
// character select.
// ----------------------------------------------------------------------------
module sfxa_datapath import sfxa_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  cmd_t                       cmd,
  output status_t                    stat,
  input  logic signed [NUM_W-1:0]    number,
  input  logic        [PLACES_W-1:0] decimal_places,
  input  logic        [CAP_W-1:0]    capacity,
  output logic        [CHAR_W-1:0]   char_code,
  output logic                       fits
);

  logic [NUM_W-1:0]       x;
  logic [DIGIT_IDX_W-1:0] step;
  logic [DIGIT_IDX_W-1:0] ndig_raw;
  logic [DIGIT_IDX_W-1:0] k;
  logic [PLACES_W-1:0]    places;
  logic [CAP_W-1:0]       cap;
  logic                   neg;
  logic [DIGIT_W-1:0]     digits [NUM_DIGITS];

  logic [2*NUM_W-1:0]             prod;
  logic [NUM_W-RECIP_SHIFT+NUM_W-1:0] q;
  logic [NUM_W-1:0]               q_times_ten;
  logic [NUM_W-1:0]               rem_full;
  logic [DIGIT_W-1:0]             rem;
  logic [DIGIT_IDX_W:0]           places_p1;
  logic [DIGIT_IDX_W:0]           ndig_eff;
  logic [DIGIT_IDX_W+1:0]         len;

  // one decimal digit per step via reciprocal multiply
  assign prod        = {{NUM_W{1'b0}}, x} * {{NUM_W{1'b0}}, RECIP_TEN};
  assign q           = prod[2*NUM_W-1:RECIP_SHIFT];
  assign q_times_ten = {q, 3'b000} + {2'b00, q, 1'b0};
  assign rem_full    = x - q_times_ten;
  assign rem         = rem_full[DIGIT_W-1:0];

  // digit count with zero padding ahead of the point
  assign places_p1 = {1'b0, places} + 5'd1;
  assign ndig_eff  = ({1'b0, ndig_raw} < places_p1) ? places_p1 : {1'b0, ndig_raw};
  assign len       = {1'b0, ndig_eff} + {5'd0, neg} + {5'd0, (places != '0)};

  // status back to the controller
  assign stat.fits       = (places <= MAX_PLACES) && ({2'b00, len} < cap);
  assign stat.neg        = neg;
  assign stat.div_done   = (step == DIGIT_IDX_W'(NUM_DIGITS - 1));
  assign stat.k_zero     = (k == '0);
  assign stat.k_at_point = (places != '0) && (k == places);

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (cmd.load) begin
      step <= '0;
    end else if (cmd.div_step) begin
      step <= step + 4'd1;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg      <= number[NUM_W-1];
      x        <= number[NUM_W-1] ? (NUM_W'(0) - NUM_W'(number)) : NUM_W'(number);
      places   <= decimal_places;
      cap      <= capacity;
      ndig_raw <= '0;
    end else if (cmd.div_step) begin
      x            <= {3'b000, q};
      digits[step] <= rem;
      if (x != '0) begin
        ndig_raw <= step + 4'd1;
      end
    end
    if (cmd.load_k) begin
      k <= ndig_eff[DIGIT_IDX_W-1:0] - 4'd1;
    end else if (cmd.digit_dec) begin
      k <= k - 4'd1;
    end
  end

  // character select
  always_comb begin
    case (cmd.sel)
      CHAR_SIGN:  char_code = ASCII_MINUS;
      CHAR_DIGIT: char_code = ASCII_ZERO + {3'b000, digits[k]};
      CHAR_POINT: char_code = ASCII_POINT;
      default:    char_code = ASCII_NONE;
    endcase
  end

  assign fits = (cmd.sel != CHAR_FAIL);

endmodule

/* rtl/sfxa_ctrl.sv */
// ----------------------------------------------------------------------------
// sfxa_ctrl
// Sequencer: accept, ten divide steps, length check, then sign, digits and
// point in string order, or a single failure word.
// ----------------------------------------------------------------------------
module sfxa_ctrl import sfxa_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  status_t stat,
  output cmd_t    cmd,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output logic    out_last
);

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DIV;
      end
      S_DIV: begin
        if (stat.div_done) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (!stat.fits)    state_next = S_FAIL;
        else if (stat.neg) state_next = S_SIGN;
        else               state_next = S_DIGIT;
      end
      S_SIGN: begin
        if (out_ready) state_next = S_DIGIT;
      end
      S_DIGIT: begin
        if (out_ready) begin
          if (stat.k_zero)          state_next = S_IDLE;
          else if (stat.k_at_point) state_next = S_POINT;
          else                      state_next = S_DIGIT;
        end
      end
      S_POINT: begin
        if (out_ready) state_next = S_DIGIT;
      end
      S_FAIL: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '{load: 1'b0, div_step: 1'b0, load_k: 1'b0, digit_dec: 1'b0,
                  sel: CHAR_FAIL};
    in_ready  = 1'b0;
    out_valid = 1'b0;
    out_last  = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
      end
      S_CHECK: begin
        cmd.load_k = 1'b1;
      end
      S_SIGN: begin
        out_valid = 1'b1;
        cmd.sel   = CHAR_SIGN;
      end
      S_DIGIT: begin
        out_valid     = 1'b1;
        out_last      = stat.k_zero;
        cmd.sel       = CHAR_DIGIT;
        cmd.digit_dec = out_ready;
      end
      S_POINT: begin
        out_valid = 1'b1;
        cmd.sel   = CHAR_POINT;
      end
      S_FAIL: begin
        out_valid = 1'b1;
        out_last  = 1'b1;
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  // no new word is taken while text is still going out
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input accepted while output pending");

  // the divide phase ends after the last digit step
  a_div_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && stat.div_done) |=> (state == S_CHECK))
    else $error("divide phase did not end");

  // a point is always followed by at least one digit
  a_point_not_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_POINT && out_ready) |=> (state == S_DIGIT))
    else $error("point not followed by a digit");

  // after the final word the block is ready again
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && out_last) |=> in_ready)
    else $error("not idle after final word");
`endif

endmodule

/* rtl/signed_fixed_point_to_decimal_ascii_core.sv */
// After an input is accepted, ten divide-by-ten steps and a length check
// come before the first output word. Each input gives 1 to 12 output words,
// and a new input is taken only after the last word of the previous one.
// Words go out one per cycle while the sink is ready.
// Reset: synchronous active-high rst returns the sequencer to idle, ready for input.
// ----------------------------------------------------------------------------
// signed_fixed_point_to_decimal_ascii_core
// Prints a signed 32-bit value as decimal text with an optional point,
// one ascii character per output word, or a single failure word when the
// text does not fit the given capacity or more than nine places are asked.
// ----------------------------------------------------------------------------
module signed_fixed_point_to_decimal_ascii_core import sfxa_pkg::*; (
  input logic      clk,
  input logic      rst,
  sfxa_in_if.sink  din,
  sfxa_out_if.source dout
);

  cmd_t    cmd;
  status_t stat;

  // sequencer
  sfxa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .stat      (stat),
    .cmd       (cmd),
    .in_valid  (din.valid),
    .in_ready  (din.ready),
    .out_valid (dout.valid),
    .out_ready (dout.ready),
    .out_last  (dout.last)
  );

  // datapath
  sfxa_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .number         (din.number),
    .decimal_places (din.decimal_places),
    .capacity       (din.capacity),
    .char_code      (dout.char_code),
    .fits           (dout.fits)
  );

endmodule

/* tb/sv/signed_fixed_point_to_decimal_ascii_core_tb.sv */
// ----------------------------------------------------------------------------
// signed_fixed_point_to_decimal_ascii_core_tb
// Drives signed values with decimal places and buffer capacities into the
// text core and checks every output word against a local formatter or typed text.
// A table of corner cases comes first, then 150 random items. Both
// the sender and the receiver insert random gaps.
// ----------------------------------------------------------------------------
module signed_fixed_point_to_decimal_ascii_core_tb;
  import sfxa_pkg::*;

  localparam int TEXT_MAX    = 12;
  localparam int RANDOM_ITEMS = 150;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 40;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              fits;
    logic              last;
  } text_word_t;

  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_TEXT,
    ROW_REJECT
  } row_kind_t;

  typedef struct packed {
    logic [NUM_W-1:0]    num;
    logic [PLACES_W-1:0] places;
    logic [CAP_W-1:0]    cap;
    row_kind_t           kind;
    logic [8*TEXT_MAX-1:0] text;
  } corner_row_t;

  logic clk;
  logic rst;

  sfxa_in_if  in_bus ();
  sfxa_out_if out_bus ();

  signed_fixed_point_to_decimal_ascii_core dut (
    .clk  (clk),
    .rst  (rst),
    .din  (in_bus),
    .dout (out_bus)
  );

  text_word_t  text_q[$];
  corner_row_t corner_rows[$];

  int  err_count;
  int  items_sent;
  int  neg_items;
  int  chars_seen;
  int  rejects_seen;
  int  cycle_count;
  bit  idle_on;
  bit  word_taken;

  // clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // single rejection word
  function automatic void push_reject();
    text_q.push_back('{char_code: ASCII_NONE, fits: 1'b0, last: 1'b1});
  endfunction

  // formats a value into the expected character words
  function automatic void predict_text(input logic [NUM_W-1:0] num,
                                       input logic [PLACES_W-1:0] places,
                                       input logic [CAP_W-1:0] cap);
    logic              neg;
    logic [NUM_W-1:0]  mag;
    logic [NUM_W-1:0]  rest;
    int                ndig;
    int                len;
    int                pos;
    logic [CHAR_W-1:0] chars [TEXT_MAX];
    neg = num[NUM_W-1];
    mag = neg ? -num : num;
    if (places > MAX_PLACES) begin
      push_reject();
      return;
    end
    // digit count, padded to keep one digit before the point
    ndig = 0;
    rest = mag;
    while (rest != 0) begin
      rest = rest / 10;
      ndig++;
    end
    if (ndig < int'(places) + 1) ndig = int'(places) + 1;
    len = ndig + int'(neg) + int'(places != 0);
    if (len + 1 > int'(cap) || len > TEXT_MAX) begin
      push_reject();
      return;
    end
    // fill right to left
    pos = len;
    rest = mag;
    for (int i = 0; i < ndig; i++) begin
      if (places != 0 && i == int'(places)) begin
        pos--;
        chars[pos] = ASCII_POINT;
      end
      pos--;
      chars[pos] = ASCII_ZERO + CHAR_W'(rest % 10);
      rest = rest / 10;
    end
    if (neg) chars[0] = ASCII_MINUS;
    for (int i = 0; i < len; i++) begin
      text_q.push_back('{char_code: chars[i], fits: 1'b1, last: (i == len - 1)});
    end
  endfunction

  // typed text, right-justified in the vector
  function automatic void push_typed_text(input logic [8*TEXT_MAX-1:0] text);
    for (int k = TEXT_MAX - 1; k >= 0; k--) begin
      if (text[k*8 +: 8] != 8'd0) begin
        text_q.push_back('{char_code: text[k*8 +: CHAR_W], fits: 1'b1, last: 1'b0});
      end
    end
    text_q[text_q.size()-1].last = 1'b1;
  endfunction

  function automatic void add_row(input logic [NUM_W-1:0] num,
                                  input logic [PLACES_W-1:0] places,
                                  input logic [CAP_W-1:0] cap,
                                  input row_kind_t kind,
                                  input logic [8*TEXT_MAX-1:0] text);
    corner_rows.push_back('{num: num, places: places, cap: cap, kind: kind, text: text});
  endfunction

  // presents one word after a random gap and waits for acceptance
  task automatic send_item(input logic [NUM_W-1:0] num,
                           input logic [PLACES_W-1:0] places,
                           input logic [CAP_W-1:0] cap);
    int gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_bus.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_bus.valid          <= 1'b1;
    in_bus.number         <= num;
    in_bus.decimal_places <= places;
    in_bus.capacity       <= cap;
    do @(posedge clk); while (!in_bus.ready);
    items_sent++;
    if (num[NUM_W-1]) neg_items++;
  endtask

  // hold off the sender until every expected word is back
  task automatic drain_text();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (text_q.size() != 0) @(posedge clk);
  endtask

  // receiver: random stall before each word
  initial begin
    int stall;
    stall = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (word_taken) begin
        stall = idle_on ? $urandom_range(0, 3) : 0;
        word_taken = 1'b0;
      end
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        stall--;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // compare each accepted word with the oldest expectation
  always @(posedge clk) begin
    text_word_t want;
    if (!rst && out_bus.valid && out_bus.ready) begin
      word_taken = 1'b1;
      if (text_q.size() == 0) begin
        $error("unexpected word: char_code=%h fits=%b last=%b",
               out_bus.char_code, out_bus.fits, out_bus.last);
        err_count++;
      end else begin
        want = text_q.pop_front();
        if (out_bus.char_code !== want.char_code) begin
          $error("char_code: expected %h, got %h", want.char_code, out_bus.char_code);
          err_count++;
        end
        if (out_bus.fits !== want.fits) begin
          $error("fits: expected %b, got %b", want.fits, out_bus.fits);
          err_count++;
        end
        if (out_bus.last !== want.last) begin
          $error("last: expected %b, got %b", want.last, out_bus.last);
          err_count++;
        end
        if (want.fits) chars_seen++;
        else rejects_seen++;
      end
    end
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // stimulus
  initial begin
    logic [NUM_W-1:0]    num;
    logic [PLACES_W-1:0] places;
    logic [CAP_W-1:0]    cap;
    int                  pick;
    err_count    = 0;
    items_sent   = 0;
    neg_items    = 0;
    chars_seen   = 0;
    rejects_seen = 0;
    word_taken   = 1'b0;
    idle_on      = 1'b1;
    rst                   = 1'b1;
    in_bus.valid          = 1'b0;
    in_bus.number         = '0;
    in_bus.decimal_places = '0;
    in_bus.capacity       = '0;

    // corner cases: zero, capacity edges, extremes, bad place counts
    add_row(32'sd0,           4'd0,  8'd2,   ROW_TEXT,    "0");
    add_row(32'sd0,           4'd2,  8'd5,   ROW_TEXT,    "0.00");
    add_row(32'sd0,           4'd2,  8'd4,   ROW_REJECT,  '0);
    add_row(32'sd1,           4'd0,  8'd0,   ROW_REJECT,  '0);
    add_row(32'sh7FFF_FFFF,   4'd0,  8'd11,  ROW_TEXT,    "2147483647");
    add_row(32'sh7FFF_FFFF,   4'd0,  8'd10,  ROW_REJECT,  '0);
    add_row(32'sh8000_0000,   4'd0,  8'd12,  ROW_TEXT,    "-2147483648");
    add_row(32'sh8000_0000,   4'd9,  8'd13,  ROW_TEXT,    "-2.147483648");
    add_row(32'sh8000_0000,   4'd9,  8'd12,  ROW_REJECT,  '0);
    add_row(-32'sd1,          4'd9,  8'd255, ROW_TEXT,    "-0.000000001");
    add_row(32'sd5,           4'd1,  8'd255, ROW_PREDICT, '0);
    add_row(32'sd123456,      4'd3,  8'd255, ROW_PREDICT, '0);
    add_row(-32'sd7,          4'd0,  8'd3,   ROW_TEXT,    "-7");
    add_row(-32'sd7,          4'd0,  8'd2,   ROW_REJECT,  '0);
    add_row(32'sd12345,       4'd10, 8'd255, ROW_REJECT,  '0);
    add_row(32'sd12345,       4'd15, 8'd255, ROW_REJECT,  '0);
    add_row(32'sd0,           4'd9,  8'd12,  ROW_TEXT,    "0.000000000");
    add_row(32'sd0,           4'd9,  8'd11,  ROW_REJECT,  '0);
    add_row(32'sd999999999,   4'd9,  8'd255, ROW_PREDICT, '0);
    add_row(32'sd1000000000,  4'd9,  8'd255, ROW_PREDICT, '0);
    add_row(-32'sd10,         4'd1,  8'd255, ROW_PREDICT, '0);
    add_row(32'sd42,          4'd8,  8'd128, ROW_PREDICT, '0);
    add_row(-32'sd98765,      4'd4,  8'd9,   ROW_PREDICT, '0);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (corner_rows[r]) begin
      send_item(corner_rows[r].num, corner_rows[r].places, corner_rows[r].cap);
      case (corner_rows[r].kind)
        ROW_TEXT:   push_typed_text(corner_rows[r].text);
        ROW_REJECT: push_reject();
        default:    predict_text(corner_rows[r].num, corner_rows[r].places,
                                 corner_rows[r].cap);
      endcase
    end
    drain_text();

    // random items; every third stretch of 25 runs without gaps
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      idle_on = ((i / 25) % 3) != 2;
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        num = $urandom;
      end else if (pick < 6) begin
        num = $urandom_range(0, 999);
      end else if (pick == 6) begin
        num = $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 3)
                                   : 32'h8000_0000 + $urandom_range(0, 3);
      end else begin
        num = $urandom_range(0, 99999999);
      end
      if (pick >= 4 && pick != 6 && $urandom_range(0, 1)) num = -num;
      if ($urandom_range(0, 9) == 0) places = PLACES_W'($urandom_range(10, 15));
      else places = PLACES_W'($urandom_range(0, 9));
      pick = $urandom_range(0, 9);
      if (pick < 6) cap = CAP_W'($urandom_range(13, 255));
      else if (pick < 9) cap = CAP_W'($urandom_range(0, 14));
      else cap = CAP_W'($urandom_range(0, 255));
      send_item(num, places, cap);
      predict_text(num, places, cap);
      if (i == RANDOM_ITEMS / 2) drain_text();
    end

    // let the last words out, then watch for strays
    drain_text();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d items (%0d negative): %0d characters and %0d rejections checked.",
             items_sent, neg_items, chars_seen, rejects_seen);
    if (err_count == 0 && text_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
